// ===== hw/rtl/att_pkg.sv =====
`timescale 1ns / 1ps

package att_pkg;

    localparam int CP_W    = 21;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 16;
    localparam int COLOR_W = 24;
    localparam int PARAM_W = 10;
    localparam int NUM_PARAMS = 3;

    localparam int SCREEN_WIDTH_DEF = 800;
    localparam int CHAR_WIDTH_DEF   = 8;
    localparam int LINE_HEIGHT_DEF  = 16;

    localparam logic [ROW_W-1:0]   ROW_MAX   = 16'd65520;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;

    localparam logic OP_PUT    = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;
    localparam logic CMD_DRAW  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [CP_W-1:0] CH_BS       = 21'h08;
    localparam logic [CP_W-1:0] CH_NL       = 21'h0A;
    localparam logic [CP_W-1:0] CH_CR       = 21'h0D;
    localparam logic [CP_W-1:0] CH_ESC      = 21'h1B;
    localparam logic [CP_W-1:0] CH_SPACE    = 21'h20;
    localparam logic [CP_W-1:0] CH_DIGIT0   = 21'h30;
    localparam logic [CP_W-1:0] CH_DIGIT9   = 21'h39;
    localparam logic [CP_W-1:0] CH_SEMI     = 21'h3B;
    localparam logic [CP_W-1:0] CH_LBRACKET = 21'h5B;
    localparam logic [CP_W-1:0] CH_SGR_END  = 21'h6D;

    localparam logic [COLOR_W-1:0] FG_PURPLE = 24'hFF00FF;
    localparam logic [COLOR_W-1:0] FG_CYAN   = 24'h00FFFF;
    localparam logic [COLOR_W-1:0] FG_GREEN  = 24'h00FF00;
    localparam logic [COLOR_W-1:0] FG_GOLD   = 24'hFFD700;
    localparam logic [COLOR_W-1:0] FG_WHITE  = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] FG_DIM    = 24'h808080;

    localparam logic [PARAM_W-1:0] SGR_RESET  = 10'd0;
    localparam logic [PARAM_W-1:0] SGR_DIM    = 10'd2;
    localparam logic [PARAM_W-1:0] SGR_GREEN  = 10'd32;
    localparam logic [PARAM_W-1:0] SGR_GOLD   = 10'd33;
    localparam logic [PARAM_W-1:0] SGR_PURPLE = 10'd35;
    localparam logic [PARAM_W-1:0] SGR_CYAN   = 10'd36;

    typedef struct packed {
        logic               command;
        logic [COL_W-1:0]   pos_x;
        logic [ROW_W-1:0]   pos_y;
        logic [CP_W-1:0]    glyph;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
    } t_draw;

endpackage

// ===== hw/rtl/att_core.sv =====
`timescale 1ns / 1ps

module att_core #(
    parameter int SCREEN_WIDTH = att_pkg::SCREEN_WIDTH_DEF,
    parameter int CHAR_WIDTH   = att_pkg::CHAR_WIDTH_DEF,
    parameter int LINE_HEIGHT  = att_pkg::LINE_HEIGHT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_step,
    input  logic                             i_op,
    input  logic [att_pkg::CP_W-1:0]         i_cp,
    input  logic [att_pkg::COLOR_W-1:0]      i_back_color,
    output logic                             o_res_valid,
    output att_pkg::t_draw                   o_res
);
    import att_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_ESC  = 2'd1,
        ST_SEQ  = 2'd2
    } t_stage;

    t_stage                    r_stage, n_stage;
    logic [PARAM_W-1:0]        r_vals [NUM_PARAMS];
    logic [PARAM_W-1:0]        n_vals [NUM_PARAMS];
    logic [1:0]                r_idx, n_idx;
    logic [COL_W-1:0]          r_col, n_col;
    logic [ROW_W-1:0]          r_row, n_row;
    logic [COLOR_W-1:0]        r_fg, n_fg;

    logic                      plain;
    logic                      is_digit;
    logic [PARAM_W-1:0]        cur_val;
    logic [13:0]               digit_sum;
    logic [PARAM_W-1:0]        digit_sat;
    logic [ROW_W:0]            row_sum;
    logic [ROW_W-1:0]          row_adv;
    logic [COL_W:0]            col_adv;
    logic [COLOR_W-1:0]        sgr_fg;

    function automatic logic [COLOR_W-1:0] sgr_color(
        input logic [PARAM_W-1:0] code,
        input logic [COLOR_W-1:0] fg
    );
        logic [COLOR_W-1:0] c;
        c = fg;
        case (code)
            SGR_RESET:  c = FG_WHITE;
            SGR_PURPLE: c = FG_PURPLE;
            SGR_CYAN:   c = FG_CYAN;
            SGR_GREEN:  c = FG_GREEN;
            SGR_GOLD:   c = FG_GOLD;
            SGR_DIM:    c = FG_DIM;
            default:    c = fg;
        endcase
        return c;
    endfunction

    always_comb begin
        case (r_idx)
            2'd0:    cur_val = r_vals[0];
            2'd1:    cur_val = r_vals[1];
            default: cur_val = r_vals[2];
        endcase
    end

    assign is_digit  = (i_cp >= CH_DIGIT0) && (i_cp <= CH_DIGIT9);
    assign digit_sum = 14'(cur_val) * 14'd10 + 14'(i_cp[3:0]);
    assign digit_sat = (digit_sum > 14'(PARAM_MAX)) ? PARAM_MAX : digit_sum[PARAM_W-1:0];
    assign row_sum   = {1'b0, r_row} + (ROW_W+1)'(LINE_HEIGHT);
    assign row_adv   = (row_sum > (ROW_W+1)'(ROW_MAX)) ? ROW_MAX : row_sum[ROW_W-1:0];
    assign col_adv   = {1'b0, r_col} + (COL_W+1)'(CHAR_WIDTH);

    always_comb begin
        sgr_fg = r_fg;
        for (int i = 0; i < NUM_PARAMS; i++) begin
            if (2'(i) <= r_idx) begin
                sgr_fg = sgr_color(r_vals[i], sgr_fg);
            end
        end
    end

    always_comb begin
        n_stage = r_stage;
        n_vals  = r_vals;
        n_idx   = r_idx;
        n_col   = r_col;
        n_row   = r_row;
        n_fg    = r_fg;
        plain   = 1'b0;
        o_res_valid      = 1'b0;
        o_res.command    = CMD_DRAW;
        o_res.pos_x      = '0;
        o_res.pos_y      = '0;
        o_res.glyph      = '0;
        o_res.fore_color = r_fg;
        o_res.back_color = i_back_color;
        if (i_op == OP_CLEAR) begin
            n_col         = '0;
            n_row         = '0;
            n_stage       = ST_IDLE;
            o_res_valid   = 1'b1;
            o_res.command = CMD_CLEAR;
        end else begin
            case (r_stage)
                ST_ESC: begin
                    n_stage = ST_IDLE;
                    if (i_cp == CH_LBRACKET) begin
                        n_stage = ST_SEQ;
                        for (int i = 0; i < NUM_PARAMS; i++) begin
                            n_vals[i] = '0;
                        end
                        n_idx = '0;
                    end else begin
                        plain = 1'b1;
                    end
                end
                ST_SEQ: begin
                    n_stage = ST_IDLE;
                    if (is_digit) begin
                        n_stage = ST_SEQ;
                        for (int i = 0; i < NUM_PARAMS; i++) begin
                            if (r_idx == 2'(i)) begin
                                n_vals[i] = digit_sat;
                            end
                        end
                    end else if (i_cp == CH_SEMI) begin
                        n_stage = ST_SEQ;
                        if (r_idx < 2'(NUM_PARAMS - 1)) begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else if (i_cp == CH_SGR_END) begin
                        n_fg = sgr_fg;
                    end
                end
                default: begin
                    n_stage = ST_IDLE;
                    if (i_cp == CH_ESC) begin
                        n_stage = ST_ESC;
                    end else begin
                        plain = 1'b1;
                    end
                end
            endcase
            if (plain) begin
                if (i_cp == CH_NL) begin
                    n_row = row_adv;
                    n_col = '0;
                end else if (i_cp == CH_CR) begin
                    n_col = '0;
                end else if (i_cp == CH_BS) begin
                    if (r_col >= COL_W'(CHAR_WIDTH)) begin
                        n_col = r_col - COL_W'(CHAR_WIDTH);
                    end
                    o_res_valid = 1'b1;
                    o_res.pos_x = n_col;
                    o_res.pos_y = r_row;
                    o_res.glyph = CH_SPACE;
                end else begin
                    o_res_valid = 1'b1;
                    o_res.pos_x = r_col;
                    o_res.pos_y = r_row;
                    o_res.glyph = i_cp;
                    if (col_adv >= (COL_W+1)'(SCREEN_WIDTH)) begin
                        n_col = '0;
                        n_row = row_adv;
                    end else begin
                        n_col = col_adv[COL_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ST_IDLE;
            for (int i = 0; i < NUM_PARAMS; i++) begin
                r_vals[i] <= '0;
            end
            r_idx <= '0;
            r_col <= '0;
            r_row <= '0;
            r_fg  <= FG_WHITE;
        end else if (i_step) begin
            r_stage <= n_stage;
            r_vals  <= n_vals;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_row   <= n_row;
            r_fg    <= n_fg;
        end
    end

endmodule

// ===== hw/rtl/ansi_text_terminal_controller_top.sv =====
`timescale 1ns / 1ps

// text terminal front end with a small ansi color escape parser
// slave stream: one request per transfer, tuser = operation (1 clear, 0 put),
//   tdata[20:0] = code point
// master stream: zero or one draw or clear command per request, tuser = command,
//   tdata holds pos_x, pos_y, glyph, fore_color, back_color from bit 0 up
// config: i_cfg_wr_en with i_cfg_wr_data loads the background color, write it
//   only while no request is in flight
// a request passes through one register stage in front of the parser and one
//   output register after it
// throughput: one request per cycle while the receiver does not stall, the cursor
//   and parser state are updated by one shallow pass of logic per request
// an escape request in idle, newline and carriage return requests, and requests from
//   an escape [ through the sequence end give no command; other codes after escape are plain text
// reset: cursor home, parser idle, foreground white, background black, both
//   stream registers empty, s_axis_tready low while reset is held
// when the receiver stalls the output register holds, one more request is
//   taken into the input register, then s_axis_tready drops until it drains
module ansi_text_terminal_controller_top #(
    parameter int SCREEN_WIDTH = att_pkg::SCREEN_WIDTH_DEF,
    parameter int CHAR_WIDTH   = att_pkg::CHAR_WIDTH_DEF,
    parameter int LINE_HEIGHT  = att_pkg::LINE_HEIGHT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [att_pkg::COLOR_W-1:0]  i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,   // codepoint
    input  logic                         s_axis_tuser,   // operation
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [95:0]                  m_axis_tdata,   // pos_x, pos_y, glyph, fore_color, back_color
    output logic                         m_axis_tuser    // command
);
    import att_pkg::*;

    logic                r_in_valid;
    logic                r_op;
    logic [CP_W-1:0]     r_cp;
    logic [COLOR_W-1:0]  r_back_color;
    logic                r_out_valid;
    t_draw               r_out;

    logic                s_accept;
    logic                advance;
    logic                res_valid;
    t_draw               res;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = i_rst_n && (!r_in_valid || advance);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    att_core #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .CHAR_WIDTH   (CHAR_WIDTH),
        .LINE_HEIGHT  (LINE_HEIGHT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_op         (r_op),
        .i_cp         (r_cp),
        .i_back_color (r_back_color),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_back_color <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_back_color <= i_cfg_wr_data;
            end
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= res_valid;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op <= s_axis_tuser;
            r_cp <= s_axis_tdata[CP_W-1:0];
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.command;
    assign m_axis_tdata  = {1'b0, r_out.back_color, r_out.fore_color, r_out.glyph,
                            r_out.pos_y, r_out.pos_x};

endmodule

// ===== hw/rtl/att_checker.sv =====
`timescale 1ns / 1ps

module att_checker #(
    parameter int SCREEN_WIDTH = att_pkg::SCREEN_WIDTH_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import att_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |-> !s_axis_tready ##1 !m_axis_tvalid)
        else $error("output valid or input ready after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled command changed");

    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == CMD_CLEAR) |-> m_axis_tdata[46:0] == '0)
        else $error("clear command with nonzero position or glyph");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[9:0]) < SCREEN_WIDTH)
        else $error("column beyond screen width");

    a_fg_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[70:47] != '0)
        else $error("foreground color is black");

endmodule

bind ansi_text_terminal_controller_top att_checker #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
) u_att_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
